// ----- src/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Types, constants and helpers shared by the spectrum column colourizer.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MATRIX_WIDTH = 16;
    localparam logic [3:0] MATRIX_LAST = 4'(MATRIX_WIDTH - 1);

    localparam int MUL_A_W = 15;
    localparam int MUL_B_W = 8;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [1:0] CFG_DISPLAY_MODE = 2'd0;
    localparam logic [1:0] CFG_FIXED_HUE    = 2'd1;
    localparam logic [1:0] CFG_RAINBOW_RATE = 2'd2;

    localparam logic [2:0] MODE_SPECTRO      = 3'd0;
    localparam logic [2:0] MODE_COLOR_HALF   = 3'd1;
    localparam logic [2:0] MODE_COLOR_FULL   = 3'd2;
    localparam logic [2:0] MODE_RAINBOW_HALF = 3'd3;
    localparam logic [2:0] MODE_RAINBOW_FULL = 3'd4;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [8:0] HUE_WRAP  = 9'd360;
    localparam logic [8:0] VAL_ONE   = 9'd256;
    localparam logic [7:0] HUE_SPAN  = 8'd240;
    localparam logic [7:0] CH_SCALE  = 8'd17;

    typedef struct packed {
        logic [3:0] band_index;
        logic [8:0] band_value;
    } t_scc_in;

    typedef struct packed {
        logic [3:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_scc_out;

    typedef struct packed {
        logic [2:0] display_mode;
        logic [8:0] fixed_hue;
        logic [8:0] rainbow_hue;
    } t_scc_ctl;

    // pick the primary, secondary or zero component for one channel
    function automatic logic [14:0] chan_comp(input logic [2:0] sect, input logic [1:0] ch,
                                              input logic [14:0] cn, input logic [14:0] xn);
        logic [14:0] res;
        res = '0;
        case (sect)
            3'd0: res = (ch == CH_RED) ? cn : (ch == CH_GREEN) ? xn : 15'd0;
            3'd1: res = (ch == CH_RED) ? xn : (ch == CH_GREEN) ? cn : 15'd0;
            3'd2: res = (ch == CH_RED) ? 15'd0 : (ch == CH_GREEN) ? cn : xn;
            3'd3: res = (ch == CH_RED) ? 15'd0 : (ch == CH_GREEN) ? xn : cn;
            3'd4: res = (ch == CH_RED) ? xn : (ch == CH_GREEN) ? 15'd0 : cn;
            default: res = (ch == CH_RED) ? cn : (ch == CH_GREEN) ? 15'd0 : xn;
        endcase
        return res;
    endfunction

endpackage

// ----- src/scc_mul.sv -----
// ----------------------------------------------------------------------------
// scc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module scc_mul (
    input  logic                         i_clk,
    input  logic [scc_pkg::MUL_A_W-1:0]  i_a,
    input  logic [scc_pkg::MUL_B_W-1:0]  i_b,
    output logic [scc_pkg::PROD_W-1:0]   o_prod
);

    logic [scc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= scc_pkg::PROD_W'(i_a) * scc_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- src/scc_core.sv -----
// ----------------------------------------------------------------------------
// scc_core
// Sequencer and datapath: hue, chroma and channel steps over the multiplier.
// ----------------------------------------------------------------------------
module scc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scc_pkg::t_scc_ctl             i_ctl,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  scc_pkg::t_scc_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output scc_pkg::t_scc_out             o_out_data,
    output logic [scc_pkg::MUL_A_W-1:0]   o_mul_a,
    output logic [scc_pkg::MUL_B_W-1:0]   o_mul_b,
    input  logic [scc_pkg::PROD_W-1:0]    i_prod
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_HUE  = 8'b0000_0010,
        S_SECT = 8'b0000_0100,
        S_XN   = 8'b0000_1000,
        S_RED  = 8'b0001_0000,
        S_GRN  = 8'b0010_0000,
        S_BLU  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    scc_pkg::t_scc_out r_out, n_out;

    logic [3:0]  r_led, n_led;
    logic [8:0]  r_val, n_val;
    logic        r_spec, n_spec;
    logic [8:0]  r_hsel, n_hsel;
    logic [9:0]  r_lum, n_lum;
    logic [5:0]  r_k, n_k;
    logic [2:0]  r_sect, n_sect;
    logic [14:0] r_xn, n_xn;
    logic [7:0]  r_red, n_red;
    logic [7:0]  r_grn, n_grn;

    logic        in_acc;
    logic [8:0]  vsat;
    logic [9:0]  lum_dev, c2, m;
    logic [14:0] cn, mn, xn_now;
    logic [8:0]  h, hm;
    logic [15:0] num_r, num_g, num_b;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign vsat       = (i_in_data.band_value > scc_pkg::VAL_ONE) ? scc_pkg::VAL_ONE
                                                                  : i_in_data.band_value;

    assign lum_dev = (r_lum >= 10'd256) ? (r_lum - 10'd256) : (10'd256 - r_lum);
    assign c2      = 10'((10'd256 - lum_dev) << 1);
    assign m       = (r_lum >= 10'd256) ? 10'((r_lum - 10'd256) << 1) : 10'd0;
    assign cn      = 15'({6'd0, c2} * 16'd60);
    assign mn      = 15'({6'd0, m} * 16'd60);
    assign xn_now  = (r_state == S_RED) ? i_prod[14:0] : r_xn;

    assign num_r = 16'(scc_pkg::chan_comp(r_sect, scc_pkg::CH_RED, cn, xn_now)) + 16'(mn);
    assign num_g = 16'(scc_pkg::chan_comp(r_sect, scc_pkg::CH_GREEN, cn, xn_now)) + 16'(mn);
    assign num_b = 16'(scc_pkg::chan_comp(r_sect, scc_pkg::CH_BLUE, cn, xn_now)) + 16'(mn);

    always_comb begin
        h = r_spec ? i_prod[16:8] : r_hsel;
        if (h >= scc_pkg::HUE_WRAP) begin
            h = 9'd0;
        end
        if (h >= 9'd240) begin
            hm = h - 9'd240;
        end else if (h >= 9'd120) begin
            hm = h - 9'd120;
        end else begin
            hm = h;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_led       = r_led;
        n_val       = r_val;
        n_spec      = r_spec;
        n_hsel      = r_hsel;
        n_lum       = r_lum;
        n_k         = r_k;
        n_sect      = r_sect;
        n_xn        = r_xn;
        n_red       = r_red;
        n_grn       = r_grn;
        o_mul_a     = '0;
        o_mul_b     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_led = scc_pkg::MATRIX_LAST - i_in_data.band_index;
                    n_val = vsat;
                    case (i_ctl.display_mode)
                        scc_pkg::MODE_COLOR_HALF: begin
                            n_spec = 1'b0;
                            n_hsel = i_ctl.fixed_hue;
                            n_lum  = {1'b0, vsat};
                        end
                        scc_pkg::MODE_COLOR_FULL: begin
                            n_spec = 1'b0;
                            n_hsel = i_ctl.fixed_hue;
                            n_lum  = {vsat, 1'b0};
                        end
                        scc_pkg::MODE_RAINBOW_HALF: begin
                            n_spec = 1'b0;
                            n_hsel = i_ctl.rainbow_hue;
                            n_lum  = {1'b0, vsat};
                        end
                        scc_pkg::MODE_RAINBOW_FULL: begin
                            n_spec = 1'b0;
                            n_hsel = i_ctl.rainbow_hue;
                            n_lum  = {vsat, 1'b0};
                        end
                        default: begin
                            n_spec = 1'b1;
                            n_hsel = 9'd0;
                            n_lum  = 10'd256;
                        end
                    endcase
                    n_state = S_HUE;
                end
            end
            S_HUE: begin
                o_mul_a = scc_pkg::MUL_A_W'(scc_pkg::VAL_ONE - r_val);
                o_mul_b = scc_pkg::HUE_SPAN;
                n_state = S_SECT;
            end
            S_SECT: begin
                n_k = (hm >= 9'd60) ? 6'(9'd120 - hm) : 6'(hm);
                if (h < 9'd60) begin
                    n_sect = 3'd0;
                end else if (h < 9'd120) begin
                    n_sect = 3'd1;
                end else if (h < 9'd180) begin
                    n_sect = 3'd2;
                end else if (h < 9'd240) begin
                    n_sect = 3'd3;
                end else if (h < 9'd300) begin
                    n_sect = 3'd4;
                end else begin
                    n_sect = 3'd5;
                end
                n_state = S_XN;
            end
            S_XN: begin
                o_mul_a = scc_pkg::MUL_A_W'(c2);
                o_mul_b = scc_pkg::MUL_B_W'(r_k);
                n_state = S_RED;
            end
            S_RED: begin
                n_xn    = i_prod[14:0];
                o_mul_a = num_r[14:0];
                o_mul_b = scc_pkg::CH_SCALE;
                n_state = S_GRN;
            end
            S_GRN: begin
                n_red   = i_prod[18:11];
                o_mul_a = num_g[14:0];
                o_mul_b = scc_pkg::CH_SCALE;
                n_state = S_BLU;
            end
            S_BLU: begin
                n_grn   = i_prod[18:11];
                o_mul_a = num_b[14:0];
                o_mul_b = scc_pkg::CH_SCALE;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold the blue product while the output register is stalled
                o_mul_a = num_b[14:0];
                o_mul_b = scc_pkg::CH_SCALE;
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_out.led_index = r_led;
                    n_out.red       = r_red;
                    n_out.green     = r_grn;
                    n_out.blue      = i_prod[18:11];
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_led  <= n_led;
        r_val  <= n_val;
        r_spec <= n_spec;
        r_hsel <= n_hsel;
        r_lum  <= n_lum;
        r_k    <= n_k;
        r_sect <= n_sect;
        r_xn   <= n_xn;
        r_red  <= n_red;
        r_grn  <= n_grn;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/spectrum_column_colourizer.sv -----
// Sequence: each accepted transaction runs six steps through the single shared
// multiplier plus the output hand-off; the input is stalled until that hand-off,
// which waits on the output stall, so transactions do not overlap.
// Reset: synchronous, active low; clears the sequencer, output valid, the
// configuration registers, the rate divider and the rainbow hue.
// ----------------------------------------------------------------------------
// spectrum_column_colourizer
// HSL to RGB colourizer for one spectrum band with a running rainbow hue.
// ----------------------------------------------------------------------------
module spectrum_column_colourizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  scc_pkg::t_scc_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output scc_pkg::t_scc_out  o_out_data
);

    logic [2:0] r_display_mode;
    logic [8:0] r_fixed_hue;
    logic [4:0] r_rainbow_rate;
    logic [4:0] r_rate_divider, n_rate_divider;
    logic [8:0] r_rainbow_hue, n_rainbow_hue;

    logic                          cfg_wr;
    logic                          in_acc;
    scc_pkg::t_scc_ctl             ctl;
    logic [scc_pkg::MUL_A_W-1:0]   mul_a;
    logic [scc_pkg::MUL_B_W-1:0]   mul_b;
    logic [scc_pkg::PROD_W-1:0]    prod;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= scc_pkg::MODE_SPECTRO;
            r_fixed_hue    <= '0;
            r_rainbow_rate <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                scc_pkg::CFG_DISPLAY_MODE: r_display_mode <= i_cfg_data[2:0];
                scc_pkg::CFG_FIXED_HUE:    r_fixed_hue    <= i_cfg_data;
                scc_pkg::CFG_RAINBOW_RATE: r_rainbow_rate <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // advance the rainbow once every rate+1 transactions
    always_comb begin
        n_rate_divider = r_rate_divider;
        n_rainbow_hue  = r_rainbow_hue;
        if (in_acc) begin
            if (r_rate_divider >= r_rainbow_rate) begin
                n_rate_divider = '0;
                n_rainbow_hue  = (r_rainbow_hue >= scc_pkg::HUE_WRAP - 9'd1) ? 9'd0
                                                                             : r_rainbow_hue + 9'd1;
            end else begin
                n_rate_divider = r_rate_divider + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_divider <= '0;
            r_rainbow_hue  <= '0;
        end else begin
            r_rate_divider <= n_rate_divider;
            r_rainbow_hue  <= n_rainbow_hue;
        end
    end

    assign ctl.display_mode = r_display_mode;
    assign ctl.fixed_hue    = (r_fixed_hue >= scc_pkg::HUE_WRAP) ? r_fixed_hue - scc_pkg::HUE_WRAP
                                                                 : r_fixed_hue;
    assign ctl.rainbow_hue  = r_rainbow_hue;

    scc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    scc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_mul_a     (mul_a),
        .o_mul_b     (mul_b),
        .i_prod      (prod)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepted transaction");

    a_hue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rainbow_hue < scc_pkg::HUE_WRAP)
        else $error("rainbow hue out of range");

    a_divider_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_rate_divider >= r_rainbow_rate)) |=> (r_rate_divider == 5'd0))
        else $error("rate divider not cleared on hue advance");

    a_idle_without_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && !i_in_valid) |=> !o_in_stall)
        else $error("sequencer left idle without a transaction");

endmodule

// ----- sim/tb_spectrum_column_colourizer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spectrum_column_colourizer
// Checks each band's pixel color and LED index against an in-bench HSL to RGB
// predictor that also tracks the rainbow divider. It covers directed corner
// bands, random traffic across several register settings and idle patterns,
// a full rainbow hue wrap, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_spectrum_column_colourizer;

    localparam logic [1:0] CFG_UNUSED     = 2'd3;
    localparam logic [2:0] MODE_SPARE     = 3'd5;
    localparam logic [2:0] MODE_UNDEFINED = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int BANDS_PER_SET  = 50;
    localparam int REPORT_LIMIT   = 10;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic [1:0]        cfg_index   = '0;
    logic [8:0]        cfg_data    = '0;
    logic              in_valid    = 1'b0;
    scc_pkg::t_scc_in  in_data     = '0;
    logic              out_stall   = 1'b0;
    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    scc_pkg::t_scc_out o_out_data;

    // predictor copy of the registers and the rainbow state
    logic [2:0] cur_mode      = '0;
    logic [8:0] cur_fixed_hue = '0;
    logic [4:0] cur_rate      = '0;
    logic [4:0] band_divider  = '0;
    logic [8:0] running_hue   = '0;

    scc_pkg::t_scc_out pending_pixels[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count   = 0;
    int unsigned bands_sent    = 0;
    int unsigned pixels_seen   = 0;
    int unsigned reg_writes    = 0;
    int unsigned hue_wraps     = 0;
    logic        hold_trigger  = 1'b0;
    logic        hold_seen     = 1'b0;
    int unsigned hold_left     = 0;

    spectrum_column_colourizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned channel_of(input int unsigned num);
        return ((num * 255) / 30720) & 8'hFF;
    endfunction

    function automatic scc_pkg::t_scc_out predict_pixel(input scc_pkg::t_scc_in band);
        int unsigned val, hue, lum, lum_dev, chroma2, offs, k, cn, xn, mn, rn, gn, bn, fh;
        scc_pkg::t_scc_out pix;
        val = band.band_value;
        if (val > scc_pkg::VAL_ONE)
            val = scc_pkg::VAL_ONE;
        fh = (cur_fixed_hue >= scc_pkg::HUE_WRAP) ? cur_fixed_hue - scc_pkg::HUE_WRAP
                                                  : cur_fixed_hue;
        case (cur_mode)
            scc_pkg::MODE_COLOR_HALF: begin
                hue = fh;
                lum = val;
            end
            scc_pkg::MODE_COLOR_FULL: begin
                hue = fh;
                lum = 2 * val;
            end
            scc_pkg::MODE_RAINBOW_HALF: begin
                hue = running_hue;
                lum = val;
            end
            scc_pkg::MODE_RAINBOW_FULL: begin
                hue = running_hue;
                lum = 2 * val;
            end
            default: begin
                hue = (scc_pkg::HUE_SPAN * (scc_pkg::VAL_ONE - val)) >> 8;
                lum = scc_pkg::VAL_ONE;
            end
        endcase
        if (hue >= scc_pkg::HUE_WRAP)
            hue = 0;
        lum_dev = (lum > scc_pkg::VAL_ONE) ? lum - scc_pkg::VAL_ONE : scc_pkg::VAL_ONE - lum;
        chroma2 = 2 * (scc_pkg::VAL_ONE - lum_dev);
        offs    = lum - (scc_pkg::VAL_ONE - lum_dev);
        k       = hue % 120;
        k       = 60 - ((k > 60) ? k - 60 : 60 - k);
        cn      = chroma2 * 60;
        xn      = chroma2 * k;
        mn      = offs * 60;
        if (hue < 60) begin
            rn = cn; gn = xn; bn = 0;
        end else if (hue < 120) begin
            rn = xn; gn = cn; bn = 0;
        end else if (hue < 180) begin
            rn = 0; gn = cn; bn = xn;
        end else if (hue < 240) begin
            rn = 0; gn = xn; bn = cn;
        end else if (hue < 300) begin
            rn = xn; gn = 0; bn = cn;
        end else begin
            rn = cn; gn = 0; bn = xn;
        end
        pix.led_index = scc_pkg::MATRIX_LAST - band.band_index;
        pix.red       = 8'(channel_of(rn + mn));
        pix.green     = 8'(channel_of(gn + mn));
        pix.blue      = 8'(channel_of(bn + mn));
        // advance the rainbow divider
        if (band_divider >= cur_rate) begin
            band_divider = '0;
            if (running_hue == scc_pkg::HUE_WRAP - 9'd1) begin
                running_hue = '0;
                hue_wraps++;
            end else begin
                running_hue = running_hue + 9'd1;
            end
        end else begin
            band_divider = band_divider + 5'd1;
        end
        return pix;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            scc_pkg::CFG_DISPLAY_MODE: cur_mode      = data[2:0];
            scc_pkg::CFG_FIXED_HUE:    cur_fixed_hue = data;
            scc_pkg::CFG_RAINBOW_RATE: cur_rate      = data[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [2:0] mode, input logic [8:0] hue,
                             input logic [4:0] rate);
        write_reg(scc_pkg::CFG_DISPLAY_MODE, 9'(mode));
        write_reg(scc_pkg::CFG_FIXED_HUE, hue);
        write_reg(scc_pkg::CFG_RAINBOW_RATE, 9'(rate));
        cfg_valid <= 1'b0;
    endtask

    // valid stays high after acceptance so back-to-back bands need no gap
    task automatic send_band(input logic [3:0] idx, input logic [8:0] value);
        scc_pkg::t_scc_in band;
        band.band_index = idx;
        band.band_value = value;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= band;
        do @(posedge i_clk); while (o_in_stall);
        bands_sent++;
        pending_pixels.push_back(predict_pixel(band));
    endtask

    task automatic send_random_band();
        int unsigned pick;
        logic [8:0]  value;
        pick = $urandom_range(99);
        if (pick < 80)
            value = 9'($urandom_range(0, scc_pkg::VAL_ONE));
        else if (pick < 90)
            value = pick[0] ? scc_pkg::VAL_ONE : 9'd0;
        else
            value = 9'($urandom_range(scc_pkg::VAL_ONE + 1, 511));
        send_band(4'($urandom_range(0, 15)), value);
    endtask

    // drop valid and wait until every pixel has come back
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_spectrogram_extremes();
        configure(scc_pkg::MODE_SPECTRO, 9'd0, 5'd0);
        send_band(4'd0, 9'd0);
        send_band(4'd15, 9'd1);
        send_band(4'd5, 9'd255);
        send_band(4'd10, 9'd256);
        send_band(4'd0, 9'd257);
        send_band(4'd15, 9'd511);
        quiesce();
        configure(MODE_UNDEFINED, 9'd0, 5'd0);
        send_band(4'd3, 9'd128);
        quiesce();
        configure(MODE_SPARE, 9'd0, 5'd0);
        send_band(4'd12, 9'd64);
        quiesce();
        write_reg(CFG_UNUSED, 9'h1FF);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_fixed_hue_wrap();
        configure(scc_pkg::MODE_COLOR_FULL, 9'd359, 5'd0);
        send_band(4'd1, 9'd128);
        send_band(4'd2, 9'd256);
        quiesce();
        configure(scc_pkg::MODE_COLOR_HALF, 9'd360, 5'd0);
        send_band(4'd3, 9'd256);
        send_band(4'd4, 9'd100);
        quiesce();
        configure(scc_pkg::MODE_COLOR_FULL, 9'd511, 5'd0);
        send_band(4'd6, 9'd128);
        send_band(4'd7, 9'd0);
        quiesce();
    endtask

    task automatic test_rate_lowered();
        configure(scc_pkg::MODE_RAINBOW_HALF, 9'd0, 5'd5);
        repeat (3) send_band(4'd8, 9'd200);
        quiesce();
        configure(scc_pkg::MODE_RAINBOW_FULL, 9'd0, 5'd1);
        repeat (3) send_band(4'd9, 9'd90);
        quiesce();
    endtask

    task automatic test_random_traffic();
        int unsigned pct [3][2];
        logic [2:0]  mode_x [3];
        logic [8:0]  hue_x  [3];
        logic [4:0]  rate_x [3];
        pct = '{'{26, 63}, '{63, 26}, '{0, 0}};
        mode_x = '{scc_pkg::MODE_RAINBOW_FULL, scc_pkg::MODE_RAINBOW_HALF, MODE_UNDEFINED};
        hue_x  = '{9'd0, 9'd359, 9'd511};
        rate_x = '{5'd0, 5'd31, 5'd20};
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = pct[p][0];
            recv_idle_pct = pct[p][1];
            for (int s = 0; s < 4; s++) begin
                quiesce();
                if (s == 0)
                    configure(mode_x[p], hue_x[p], rate_x[p]);
                else
                    configure(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)),
                              5'($urandom_range(0, 31)));
                repeat (BANDS_PER_SET) send_random_band();
            end
        end
        quiesce();
    endtask

    task automatic test_rainbow_wrap();
        int unsigned wraps_at_start;
        configure(scc_pkg::MODE_RAINBOW_FULL, 9'd0, 5'd0);
        wraps_at_start = hue_wraps;
        while (hue_wraps == wraps_at_start)
            send_random_band();
        repeat (8) send_random_band();
        quiesce();
    endtask

    task automatic test_output_holdoff();
        configure(scc_pkg::MODE_RAINBOW_HALF, 9'd180, 5'd2);
        hold_trigger <= ~hold_trigger;
        repeat (30) send_random_band();
        quiesce();
    endtask

    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_pixels
        scc_pkg::t_scc_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected pixel: led %0d rgb %02x %02x %02x",
                             o_out_data.led_index, o_out_data.red,
                             o_out_data.green, o_out_data.blue);
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_data.led_index !== want.led_index ||
                    o_out_data.red !== want.red || o_out_data.green !== want.green ||
                    o_out_data.blue !== want.blue) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display(
                            "mismatch: want led %0d rgb %h %h %h, got led %0d rgb %h %h %h",
                            want.led_index, want.red, want.green, want.blue,
                            o_out_data.led_index, o_out_data.red,
                            o_out_data.green, o_out_data.blue);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        send_idle_pct = 26;
        recv_idle_pct = 63;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_spectrogram_extremes();
        test_fixed_hue_wrap();
        test_rate_lowered();
        test_random_traffic();
        test_rainbow_wrap();
        test_output_holdoff();
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            error_count++;
            $display("%0d pixels never arrived", pending_pixels.size());
        end
        $display("Sent %0d bands, checked %0d pixels, %0d register writes, %0d hue wraps.",
                 bands_sent, pixels_seen, reg_writes, hue_wraps);
        $display("Covered all modes, hue wrap, saturation and output hold-off; %0d errors.",
                 error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
src/scc_pkg.sv
src/scc_mul.sv
src/scc_core.sv
src/spectrum_column_colourizer.sv
sim/tb_spectrum_column_colourizer.sv
